>>> design/csf_pkg.sv
// Carousel frame scheduler package: field widths, codes and the configuration
// bundle shared by the interfaces and all scheduler modules. No dependencies.
package csf_pkg;

	localparam int unsigned BLOCK_W  = 17;
	localparam int unsigned SLOT_W   = 13;
	localparam int unsigned REPEAT_W = 8;
	localparam int unsigned FPS_W    = 8;
	localparam int unsigned EQ_W     = 18;
	localparam int unsigned FRAME_W  = 24;
	localparam int unsigned POS_W    = 10;
	localparam int unsigned GAP_W    = 16;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned CFG_W    = 17;

	localparam int unsigned DEF_MAX_BLOCKS      = 65536;
	localparam int unsigned DEF_MAX_FPS         = 240;
	localparam int unsigned DEF_CADENCE_SECONDS = 1;
	localparam int unsigned DEF_MIN_REPAIR      = 8;
	localparam int unsigned DEF_REPAIR_RATIO    = 10;

	localparam int unsigned RECORD_KINDS = 3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_SESSION  = 2'd0,
		KIND_MANIFEST = 2'd1,
		KIND_SEGMENT  = 2'd2,
		KIND_DATA     = 2'd3
	} frame_kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_BLOCK_COUNT     = 3'd0,
		REG_REPAIR_ENABLE   = 3'd1,
		REG_SLOTS_PER_FRAME = 3'd2,
		REG_CONTROL_REPEATS = 3'd3,
		REG_FRAMES_PER_SEC  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                restart;
		logic [BLOCK_W-1:0]  block_count;
		logic                repair_enable;
		logic [SLOT_W-1:0]   slots_per_frame;
		logic [REPEAT_W-1:0] control_repeats;
		logic [FPS_W-1:0]    frames_per_second;
		logic [BLOCK_W-1:0]  repair_quot;   // (block_count - 1) / REPAIR_RATIO
	} cfg_t;

endpackage

>>> design/csf_if.sv
// Handshake interfaces for the command word and the frame word.
// Depends on csf_pkg.
interface csf_cmd_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink (input valid, input advance, output ready);
endinterface

interface csf_frame_if;
	import csf_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	frame_kind_t         frame_kind;
	logic [EQ_W-1:0]     first_equation;
	logic [SLOT_W-1:0]   equation_count;
	logic [FRAME_W-1:0]  frame_number;
	logic                round_done;

	modport source (output valid, output status, output frame_kind, output first_equation,
		output equation_count, output frame_number, output round_done, input ready);
	modport sink (input valid, input status, input frame_kind, input first_equation,
		input equation_count, input frame_number, input round_done, output ready);
endinterface

>>> design/csf_cfg_regs.sv
// Configuration registers with write decode and the precomputed repair quotient.
// Depends on csf_pkg.
module csf_cfg_regs #(
	parameter int unsigned REPAIR_RATIO = csf_pkg::DEF_REPAIR_RATIO
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [csf_pkg::IDX_W-1:0]   cfg_index,
	input  logic [csf_pkg::CFG_W-1:0]   cfg_wdata,
	output csf_pkg::cfg_t               cfg
);
	import csf_pkg::*;

	// reciprocal multiply: exact for 17-bit dividends and ratios below 128
	localparam int unsigned RecipShift = BLOCK_W + 8;
	localparam int unsigned RecipW     = RecipShift + 1;
	localparam int unsigned ProdW      = RecipW + BLOCK_W;
	localparam logic [RecipW-1:0] RecipMul = RecipW'(((64'd1 << RecipShift)
		+ 64'(REPAIR_RATIO) - 64'd1) / 64'(REPAIR_RATIO));

	logic [BLOCK_W-1:0]  block_count_q;
	logic                repair_enable_q;
	logic [SLOT_W-1:0]   slots_q;
	logic [REPEAT_W-1:0] repeats_q;
	logic [FPS_W-1:0]    fps_q;
	logic [BLOCK_W-1:0]  quot_q;

	logic [BLOCK_W-1:0]  bc_m1;
	logic [ProdW-1:0]    prod;
	logic                hit;

	assign bc_m1 = cfg_wdata[BLOCK_W-1:0] - BLOCK_W'(1);
	assign prod  = ProdW'(bc_m1) * ProdW'(RecipMul);

	always_comb begin
		case (cfg_index)
			REG_BLOCK_COUNT, REG_REPAIR_ENABLE, REG_SLOTS_PER_FRAME,
			REG_CONTROL_REPEATS, REG_FRAMES_PER_SEC: hit = cfg_we;
			default: hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q   <= BLOCK_W'(1);
			repair_enable_q <= 1'b0;
			slots_q         <= SLOT_W'(1);
			repeats_q       <= REPEAT_W'(1);
			fps_q           <= '0;
			quot_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_COUNT: begin
						block_count_q <= cfg_wdata[BLOCK_W-1:0];
						quot_q        <= prod[RecipShift +: BLOCK_W];
					end
					REG_REPAIR_ENABLE:   repair_enable_q <= cfg_wdata[0];
					REG_SLOTS_PER_FRAME: slots_q         <= cfg_wdata[SLOT_W-1:0];
					REG_CONTROL_REPEATS: repeats_q       <= cfg_wdata[REPEAT_W-1:0];
					REG_FRAMES_PER_SEC:  fps_q           <= cfg_wdata[FPS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// round restarts at the write edge
	assign cfg.restart           = hit;
	assign cfg.block_count       = block_count_q;
	assign cfg.repair_enable     = repair_enable_q;
	assign cfg.slots_per_frame   = slots_q;
	assign cfg.control_repeats   = repeats_q;
	assign cfg.frames_per_second = fps_q;
	assign cfg.repair_quot       = quot_q;

endmodule

>>> design/csf_core.sv
// Frame sequencer: round state, one frame decision per accepted command word,
// and the result register. Depends on csf_pkg and csf_if.
module csf_core #(
	parameter int unsigned MAX_BLOCKS      = csf_pkg::DEF_MAX_BLOCKS,
	parameter int unsigned MAX_FPS         = csf_pkg::DEF_MAX_FPS,
	parameter int unsigned CADENCE_SECONDS = csf_pkg::DEF_CADENCE_SECONDS,
	parameter int unsigned MIN_REPAIR      = csf_pkg::DEF_MIN_REPAIR
) (
	input  logic          clk,
	input  logic          arst_n,
	input  csf_pkg::cfg_t cfg,
	csf_cmd_if.sink       cmd,
	csf_frame_if.source   frame
);
	import csf_pkg::*;

	// round state
	logic [FRAME_W-1:0]  frame_cnt_q;
	logic                in_burst_q;
	logic [POS_W-1:0]    burst_pos_q;
	logic [REPEAT_W-1:0] repeat_cnt_q;
	logic [1:0]          record_q;
	logic [EQ_W-1:0]     eq_sent_q;
	logic [GAP_W-1:0]    gap_cnt_q;
	logic                complete_q;

	// result register
	logic                out_valid_q;
	status_t             status_q;
	frame_kind_t         kind_q;
	logic [EQ_W-1:0]     first_q;
	logic [SLOT_W-1:0]   count_q;
	logic [FRAME_W-1:0]  number_q;
	logic                done_q;

	logic                accept;
	logic                cfg_ok;
	logic [EQ_W-1:0]     repair;
	logic [EQ_W-1:0]     total;
	logic [GAP_W-1:0]    cadence;
	logic [POS_W-1:0]    burst_len;
	logic [GAP_W-1:0]    gap;
	logic [EQ_W-1:0]     left;
	logic [SLOT_W-1:0]   count;
	frame_kind_t         kind;
	logic [EQ_W-1:0]     sent_nxt;
	logic [POS_W-1:0]    pos_inc;
	logic [REPEAT_W-1:0] rep_inc;
	logic [GAP_W-1:0]    gap_inc;

	assign cmd.ready = !out_valid_q || frame.ready;
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		cfg_ok = 1'b1;
		if (cfg.block_count == '0 || 21'(cfg.block_count) > 21'(MAX_BLOCKS))
			cfg_ok = 1'b0;
		if (cfg.slots_per_frame == '0 || cfg.control_repeats == '0)
			cfg_ok = 1'b0;
		if (11'(cfg.frames_per_second) > 11'(MAX_FPS))
			cfg_ok = 1'b0;
		if (cfg.repair_enable && cfg.block_count < BLOCK_W'(2))
			cfg_ok = 1'b0;
	end

	always_comb begin
		repair = EQ_W'(cfg.repair_quot) + EQ_W'(1);
		if (repair < EQ_W'(MIN_REPAIR))
			repair = EQ_W'(MIN_REPAIR);
		if (!cfg.repair_enable)
			repair = '0;
		total = EQ_W'(cfg.block_count) + repair;
	end

	assign cadence   = GAP_W'(cfg.frames_per_second) * GAP_W'(CADENCE_SECONDS);
	assign burst_len = POS_W'(cfg.control_repeats) * POS_W'(RECORD_KINDS);

	always_comb begin
		if (cadence == '0)
			gap = '0;
		else if (cadence > GAP_W'(burst_len))
			gap = cadence - GAP_W'(burst_len);
		else
			gap = GAP_W'(1);
	end

	assign left     = total - eq_sent_q;
	assign count    = (left < EQ_W'(cfg.slots_per_frame)) ? SLOT_W'(left) : cfg.slots_per_frame;
	assign sent_nxt = eq_sent_q + EQ_W'(count);
	assign pos_inc  = burst_pos_q + POS_W'(1);
	assign rep_inc  = repeat_cnt_q + REPEAT_W'(1);
	assign gap_inc  = gap_cnt_q + GAP_W'(1);

	always_comb begin
		case (record_q)
			2'd0:    kind = KIND_SESSION;
			2'd1:    kind = KIND_MANIFEST;
			default: kind = KIND_SEGMENT;
		endcase
		if (!in_burst_q)
			kind = KIND_DATA;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q  <= '0;
			in_burst_q   <= 1'b1;
			burst_pos_q  <= '0;
			repeat_cnt_q <= '0;
			record_q     <= '0;
			eq_sent_q    <= '0;
			gap_cnt_q    <= '0;
			complete_q   <= 1'b0;
		end else if (cfg.restart) begin
			frame_cnt_q  <= '0;
			in_burst_q   <= 1'b1;
			burst_pos_q  <= '0;
			repeat_cnt_q <= '0;
			record_q     <= '0;
			eq_sent_q    <= '0;
			gap_cnt_q    <= '0;
			complete_q   <= 1'b0;
		end else if (accept && cmd.advance && cfg_ok && !complete_q) begin
			frame_cnt_q <= frame_cnt_q + FRAME_W'(1);
			if (in_burst_q) begin
				if (pos_inc >= burst_len) begin
					in_burst_q   <= 1'b0;
					burst_pos_q  <= '0;
					repeat_cnt_q <= '0;
					record_q     <= '0;
				end else begin
					burst_pos_q <= pos_inc;
					if (rep_inc >= cfg.control_repeats) begin
						repeat_cnt_q <= '0;
						record_q     <= record_q + 2'd1;
					end else begin
						repeat_cnt_q <= rep_inc;
					end
				end
			end else begin
				eq_sent_q <= sent_nxt;
				// sent reaching total is the same as the last data frame going out
				if (sent_nxt >= total) begin
					complete_q <= 1'b1;
					gap_cnt_q  <= gap_inc;
				end else if (gap != '0 && gap_inc >= gap) begin
					in_burst_q <= 1'b1;
					gap_cnt_q  <= '0;
				end else begin
					gap_cnt_q <= gap_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (frame.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!cfg_ok) begin
				status_q <= ST_INVALID;
				kind_q   <= KIND_SESSION;
				first_q  <= '0;
				count_q  <= '0;
				number_q <= '0;
				done_q   <= 1'b0;
			end else if (complete_q) begin
				status_q <= ST_COMPLETE;
				kind_q   <= KIND_SESSION;
				first_q  <= '0;
				count_q  <= '0;
				number_q <= frame_cnt_q;
				done_q   <= 1'b1;
			end else begin
				status_q <= ST_OK;
				kind_q   <= kind;
				first_q  <= in_burst_q ? '0 : eq_sent_q;
				count_q  <= in_burst_q ? '0 : count;
				number_q <= frame_cnt_q;
				done_q   <= cmd.advance && !in_burst_q && (sent_nxt >= total);
			end
		end
	end

	assign frame.valid          = out_valid_q;
	assign frame.status         = status_q;
	assign frame.frame_kind     = kind_q;
	assign frame.first_equation = first_q;
	assign frame.equation_count = count_q;
	assign frame.frame_number   = number_q;
	assign frame.round_done     = done_q;

endmodule

>>> design/carousel_frame_scheduler.sv
// Carousel frame scheduler top level: configuration registers and frame sequencer.
// A frame word appears in the cycle after its command word is accepted; one command
// word per cycle unless frame stalls; the result register decouples the two sides.
// Reset (arst_n low) restores default configuration and restarts the round with a burst.
// Depends on csf_pkg, csf_if, csf_cfg_regs and csf_core.
module carousel_frame_scheduler #(
	parameter int unsigned MAX_BLOCKS      = csf_pkg::DEF_MAX_BLOCKS,
	parameter int unsigned MAX_FPS         = csf_pkg::DEF_MAX_FPS,
	parameter int unsigned CADENCE_SECONDS = csf_pkg::DEF_CADENCE_SECONDS,
	parameter int unsigned MIN_REPAIR      = csf_pkg::DEF_MIN_REPAIR,
	parameter int unsigned REPAIR_RATIO    = csf_pkg::DEF_REPAIR_RATIO
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [csf_pkg::IDX_W-1:0] cfg_index,
	input  logic [csf_pkg::CFG_W-1:0] cfg_wdata,
	csf_cmd_if.sink                   cmd,
	csf_frame_if.source               frame
);
	import csf_pkg::*;

	cfg_t cfg;

	csf_cfg_regs #(
		.REPAIR_RATIO (REPAIR_RATIO)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	csf_core #(
		.MAX_BLOCKS      (MAX_BLOCKS),
		.MAX_FPS         (MAX_FPS),
		.CADENCE_SECONDS (CADENCE_SECONDS),
		.MIN_REPAIR      (MIN_REPAIR)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.frame  (frame)
	);

endmodule
